>>> rtl/tlik_pkg.sv
// Shared types and constants for the two-link inverse kinematics block.
// Used by the top level, the CORDIC pipeline and the port checker.
package tlik_pkg;

    localparam int CORDIC_W     = 46;   // CORDIC x/y datapath width
    localparam int ACC_W        = 34;   // Q30 angle accumulator width
    localparam int ATAN_TAB_LEN = 24;
    localparam int Q_BITS       = 25;   // cosine magnitude bits (Q24, up to one)
    localparam int ROOT_BITS    = 25;   // sine magnitude bits

    localparam logic signed [ACC_W-1:0] HALF_PI_Q30 = 34'sd1686629713;

    localparam logic [31:0] ATAN_Q30 [ATAN_TAB_LEN] = '{
        32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097148,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_OUTSIDE = 2'd1,
        ST_LIMIT   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        CFG_L1   = 2'd0,
        CFG_L2   = 2'd1,
        CFG_AMIN = 2'd2,
        CFG_AMAX = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic               pref;
    } side_t;

endpackage

>>> rtl/tlik_cordic.sv
// Pipelined vectoring CORDIC giving atan2(y, x) in Q30 radians.
// Normalises the vector in two stages, pre-rotates the left half-plane, then
// runs one micro-rotation per stage. Depends on tlik_pkg.
module tlik_cordic #(
    parameter int STAGES = 16
) (
    input  logic                                aclk,
    input  logic                                ce,
    input  logic signed [tlik_pkg::CORDIC_W-1:0] x_in,
    input  logic signed [tlik_pkg::CORDIC_W-1:0] y_in,
    output logic signed [tlik_pkg::ACC_W-1:0]    angle
);
    import tlik_pkg::*;

    localparam int W = CORDIC_W;

    logic signed [W-1:0] xa_reg, ya_reg, xb_reg, yb_reg, xc_reg, yc_reg;
    logic [W-1:0]        ma_reg;
    logic                za_reg, zb_reg, zc_reg;
    logic signed [ACC_W-1:0] accc_reg;

    logic signed [W-1:0] xa_next, ya_next, xb_next, yb_next, xc_next, yc_next;
    logic [W-1:0]        ax, ay, ma_next, mb;
    logic signed [ACC_W-1:0] accc_next;

    // Doubling until the larger magnitude reaches 2^39 is done as a binary
    // search of the shift: 32, 16, 8 in the first stage, 4, 2, 1 in the next.
    always_comb begin
        ax = x_in[W-1] ? W'(-x_in) : W'(x_in);
        ay = y_in[W-1] ? W'(-y_in) : W'(y_in);
        ma_next = (ax > ay) ? ax : ay;
        xa_next = x_in;
        ya_next = y_in;
        if (ma_next < (W'(1) << 8)) begin
            xa_next = xa_next <<< 32; ya_next = ya_next <<< 32; ma_next = ma_next << 32;
        end
        if (ma_next < (W'(1) << 24)) begin
            xa_next = xa_next <<< 16; ya_next = ya_next <<< 16; ma_next = ma_next << 16;
        end
        if (ma_next < (W'(1) << 32)) begin
            xa_next = xa_next <<< 8; ya_next = ya_next <<< 8; ma_next = ma_next << 8;
        end
    end

    always_comb begin
        xb_next = xa_reg;
        yb_next = ya_reg;
        mb      = ma_reg;
        if (mb < (W'(1) << 36)) begin
            xb_next = xb_next <<< 4; yb_next = yb_next <<< 4; mb = mb << 4;
        end
        if (mb < (W'(1) << 38)) begin
            xb_next = xb_next <<< 2; yb_next = yb_next <<< 2; mb = mb << 2;
        end
        if (mb < (W'(1) << 39)) begin
            xb_next = xb_next <<< 1; yb_next = yb_next <<< 1;
        end
    end

    always_comb begin
        xc_next   = xb_reg;
        yc_next   = yb_reg;
        accc_next = '0;
        if (xb_reg < 0) begin
            if (yb_reg >= 0) begin
                xc_next   = yb_reg;
                yc_next   = -xb_reg;
                accc_next = HALF_PI_Q30;
            end else begin
                xc_next   = -yb_reg;
                yc_next   = xb_reg;
                accc_next = -HALF_PI_Q30;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            xa_reg   <= xa_next;
            ya_reg   <= ya_next;
            ma_reg   <= ma_next;
            za_reg   <= (x_in == '0) && (y_in == '0);
            xb_reg   <= xb_next;
            yb_reg   <= yb_next;
            zb_reg   <= za_reg;
            xc_reg   <= xc_next;
            yc_reg   <= yc_next;
            accc_reg <= accc_next;
            zc_reg   <= zb_reg;
        end
    end

    logic signed [W-1:0]     xi_reg   [STAGES];
    logic signed [W-1:0]     yi_reg   [STAGES];
    logic signed [ACC_W-1:0] acci_reg [STAGES];
    logic                    zi_reg   [STAGES];

    genvar i;
    generate
        for (i = 0; i < STAGES; i++) begin : g_iter
            logic signed [W-1:0]     xp, yp, xn, yn;
            logic signed [ACC_W-1:0] ap, an, step;
            logic                    zp;

            if (i == 0) begin : g_first
                assign xp = xc_reg;
                assign yp = yc_reg;
                assign ap = accc_reg;
                assign zp = zc_reg;
            end else begin : g_rest
                assign xp = xi_reg[i-1];
                assign yp = yi_reg[i-1];
                assign ap = acci_reg[i-1];
                assign zp = zi_reg[i-1];
            end

            assign step = $signed({2'b00, ATAN_Q30[i]});

            always_comb begin
                if (yp >= 0) begin
                    xn = xp + (yp >>> i);
                    yn = yp - (xp >>> i);
                    an = ap + step;
                end else begin
                    xn = xp - (yp >>> i);
                    yn = yp + (xp >>> i);
                    an = ap - step;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    xi_reg[i]   <= xn;
                    yi_reg[i]   <= yn;
                    acci_reg[i] <= an;
                    zi_reg[i]   <= zp;
                end
            end
        end
    endgenerate

    // A zero vector gives a zero angle.
    assign angle = zi_reg[STAGES-1] ? '0 : acci_reg[STAGES-1];

endmodule

>>> rtl/two_link_inverse_kinematics.sv
// Top level of the two-link planar inverse kinematics pipeline.
// Depends on tlik_pkg and tlik_cordic.
//
// Input words arrive on the s_ channel: target x and y (Q12.4 mm) and the
// preferred elbow. Each word yields one result word on the m_ channel: the
// shoulder angle and elbow angle (angle format set by ANGLE_FRAC_BITS), the
// elbow actually used, and a status in m_tuser (ok, outside the workspace,
// or shoulder limits broken for both elbows).
// The link lengths and shoulder limits are written through the cfg_ port, one register per cycle;
// the user writes them only while no word is in flight, as the block itself does not enforce this.
// The pipeline holds three stages of squaring and workspace test, a 25-stage
// restoring divider for the cosine, a 25-stage square root for the sine,
// and five parallel CORDIC pipelines of CORDIC_STAGES + 3 stages each, then
// rounding and elbow selection.
// A new word can be accepted every cycle. When the receiver holds off
// m_tready with a result waiting, the whole pipeline freezes and s_tready
// drops; nothing is lost or repeated.
// Reset is synchronous: it empties the pipeline and restores the default
// link lengths and limits.
module two_link_inverse_kinematics #(
    parameter int ANGLE_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // target_x[15:0], target_y[31:16], prefer_up[32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // shoulder_angle[16:0], elbow_angle[32:17], elbow_used[33]
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [16:0] cfg_wdata
);
    import tlik_pkg::*;

    localparam int SH = 30 - ANGLE_FRAC_BITS;
    localparam int CL = CORDIC_STAGES + 3;
    localparam logic signed [35:0] RND = 36'sh1 << (SH - 1);

    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    // Configuration registers and values derived from them
    logic [15:0]        l1_reg, l2_reg;
    logic signed [16:0] amin_reg, amax_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l1_reg   <= 16'd4560;
            l2_reg   <= 16'd2960;
            amin_reg <= -17'sd25736;
            amax_reg <= 17'sd25736;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_L1:   l1_reg   <= cfg_wdata[15:0];
                CFG_L2:   l2_reg   <= cfg_wdata[15:0];
                CFG_AMIN: amin_reg <= $signed(cfg_wdata);
                CFG_AMAX: amax_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    logic [31:0] l1sq_reg, l2sq_reg, l1l2_reg, difsq_reg;
    logic [33:0] sumsq_reg;
    logic [32:0] lsq_reg, den_reg;
    logic        lzero_reg;
    logic [16:0] lsum;
    logic [15:0] ldif;

    assign lsum = {1'b0, l1_reg} + {1'b0, l2_reg};
    assign ldif = (l1_reg >= l2_reg) ? l1_reg - l2_reg : l2_reg - l1_reg;

    always_ff @(posedge aclk) begin
        l1sq_reg  <= l1_reg * l1_reg;
        l2sq_reg  <= l2_reg * l2_reg;
        l1l2_reg  <= l1_reg * l2_reg;
        sumsq_reg <= lsum * lsum;
        difsq_reg <= ldif * ldif;
        lzero_reg <= (l1_reg == '0) || (l2_reg == '0);
        lsq_reg   <= {1'b0, l1sq_reg} + {1'b0, l2sq_reg};
        den_reg   <= {l1l2_reg, 1'b0};
    end

    // Stage 1: squares of the target coordinates
    side_t       s_side;
    side_t       side1_reg, side2_reg, side3_reg;
    logic        vld1_reg, vld2_reg, vld3_reg;
    logic [31:0] xx_reg, yy_reg, r2_reg;
    logic signed [31:0] xx_c, yy_c;

    assign s_side.x    = $signed(s_tdata[15:0]);
    assign s_side.y    = $signed(s_tdata[31:16]);
    assign s_side.pref = s_tdata[32];
    assign xx_c = s_side.x * s_side.x;
    assign yy_c = s_side.y * s_side.y;

    // Stage 3: numerator of the cosine and workspace test
    logic signed [34:0] num;
    logic [33:0]        numabs_reg;
    logic               nneg_reg, err3_reg;

    assign num = $signed({3'b000, r2_reg}) - $signed({2'b00, lsq_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end else if (ce) begin
            vld1_reg <= s_tvalid;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            side1_reg  <= s_side;
            xx_reg     <= xx_c;
            yy_reg     <= yy_c;
            side2_reg  <= side1_reg;
            r2_reg     <= xx_reg + yy_reg;
            side3_reg  <= side2_reg;
            nneg_reg   <= num[34];
            numabs_reg <= num[34] ? 34'(-num) : num[33:0];
            err3_reg   <= lzero_reg || side2_reg.y[15] ||
                          ({2'b00, r2_reg} > sumsq_reg) || (r2_reg < difsq_reg);
        end
    end

    // Restoring divider, one quotient bit per stage: |num| * 2^24 / den
    logic        dv_vld_reg  [Q_BITS];
    logic        dv_err_reg  [Q_BITS];
    logic        dv_neg_reg  [Q_BITS];
    side_t       dv_side_reg [Q_BITS];
    logic [33:0] dv_rem_reg  [Q_BITS];
    logic [Q_BITS-1:0] dv_q_reg [Q_BITS];

    genvar j;
    generate
        for (j = 0; j < Q_BITS; j++) begin : g_div
            logic [34:0]       t;
            logic [Q_BITS-1:0] qp;
            logic              bit_q, vp, ep, np;
            side_t             sp;

            if (j == 0) begin : g_first
                assign t  = {1'b0, numabs_reg};
                assign qp = '0;
                assign vp = vld3_reg;
                assign ep = err3_reg;
                assign np = nneg_reg;
                assign sp = side3_reg;
            end else begin : g_rest
                assign t  = {dv_rem_reg[j-1], 1'b0};
                assign qp = dv_q_reg[j-1];
                assign vp = dv_vld_reg[j-1];
                assign ep = dv_err_reg[j-1];
                assign np = dv_neg_reg[j-1];
                assign sp = dv_side_reg[j-1];
            end

            assign bit_q = t >= {2'b00, den_reg};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    dv_vld_reg[j] <= 1'b0;
                end else if (ce) begin
                    dv_vld_reg[j] <= vp;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    dv_err_reg[j]  <= ep;
                    dv_neg_reg[j]  <= np;
                    dv_side_reg[j] <= sp;
                    dv_rem_reg[j]  <= bit_q ? 34'(t - {2'b00, den_reg}) : t[33:0];
                    dv_q_reg[j]    <= {qp[Q_BITS-2:0], bit_q};
                end
            end
        end
    endgenerate

    // Signed cosine, its square, and the radicand for the sine
    logic signed [25:0] c29_reg, c30_reg;
    logic [49:0]        c2_reg, v_reg;
    logic               vld29_reg, vld30_reg, err29_reg, err30_reg;
    side_t              side29_reg, side30_reg;
    logic [Q_BITS-1:0]  qf;

    assign qf = dv_q_reg[Q_BITS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld29_reg <= 1'b0;
            vld30_reg <= 1'b0;
        end else if (ce) begin
            vld29_reg <= dv_vld_reg[Q_BITS-1];
            vld30_reg <= vld29_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            c29_reg    <= dv_neg_reg[Q_BITS-1] ? -$signed({1'b0, qf}) : $signed({1'b0, qf});
            c2_reg     <= qf * qf;
            err29_reg  <= dv_err_reg[Q_BITS-1];
            side29_reg <= dv_side_reg[Q_BITS-1];
            c30_reg    <= c29_reg;
            v_reg      <= (50'd1 << 48) - c2_reg;
            err30_reg  <= err29_reg;
            side30_reg <= side29_reg;
        end
    end

    // Digit-by-digit square root, one root bit per stage
    logic                 sq_vld_reg  [ROOT_BITS];
    logic                 sq_err_reg  [ROOT_BITS];
    side_t                sq_side_reg [ROOT_BITS];
    logic signed [25:0]   sq_c_reg    [ROOT_BITS];
    logic [28:0]          sq_rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0] sq_root_reg [ROOT_BITS];
    logic [49:0]          sq_v_reg    [ROOT_BITS];

    generate
        for (j = 0; j < ROOT_BITS; j++) begin : g_sqrt
            logic [28:0]          remp, tmp, trial;
            logic [ROOT_BITS-1:0] rootp;
            logic [49:0]          vp_bits;
            logic                 ge, vp, ep;
            side_t                sp;
            logic signed [25:0]   cp;

            if (j == 0) begin : g_first
                assign remp    = '0;
                assign rootp   = '0;
                assign vp_bits = v_reg;
                assign vp      = vld30_reg;
                assign ep      = err30_reg;
                assign sp      = side30_reg;
                assign cp      = c30_reg;
            end else begin : g_rest
                assign remp    = sq_rem_reg[j-1];
                assign rootp   = sq_root_reg[j-1];
                assign vp_bits = sq_v_reg[j-1];
                assign vp      = sq_vld_reg[j-1];
                assign ep      = sq_err_reg[j-1];
                assign sp      = sq_side_reg[j-1];
                assign cp      = sq_c_reg[j-1];
            end

            assign tmp   = {remp[26:0], vp_bits[49:48]};
            assign trial = {2'b00, rootp, 2'b01};
            assign ge    = tmp >= trial;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    sq_vld_reg[j] <= 1'b0;
                end else if (ce) begin
                    sq_vld_reg[j] <= vp;
                end
            end

            always_ff @(posedge aclk) begin
                if (ce) begin
                    sq_err_reg[j]  <= ep;
                    sq_side_reg[j] <= sp;
                    sq_c_reg[j]    <= cp;
                    sq_rem_reg[j]  <= ge ? tmp - trial : tmp;
                    sq_root_reg[j] <= {rootp[ROOT_BITS-2:0], ge};
                    sq_v_reg[j]    <= {vp_bits[47:0], 2'b00};
                end
            end
        end
    endgenerate

    // Stage after the root: forearm vector terms and CORDIC operands
    logic signed [45:0] k1_reg, k2u_reg, k2d_reg, bx_reg, by_reg;
    logic signed [45:0] es_reg, ens_reg, ec_reg;
    logic               vldk_reg, errk_reg, prefk_reg;
    logic signed [25:0] sf, cf;
    logic signed [42:0] l2c, l2s;
    side_t              sidef;

    assign sf    = $signed({1'b0, sq_root_reg[ROOT_BITS-1]});
    assign cf    = sq_c_reg[ROOT_BITS-1];
    assign sidef = sq_side_reg[ROOT_BITS-1];
    assign l2c   = $signed({1'b0, l2_reg}) * cf;
    assign l2s   = $signed({1'b0, l2_reg}) * sf;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vldk_reg <= 1'b0;
        end else if (ce) begin
            vldk_reg <= sq_vld_reg[ROOT_BITS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            k1_reg    <= $signed({6'b0, l1_reg, 24'b0}) + 46'(l2c);
            k2u_reg   <= 46'(l2s);
            k2d_reg   <= -46'(l2s);
            es_reg    <= 46'(sf);
            ens_reg   <= -46'(sf);
            ec_reg    <= 46'(cf);
            bx_reg    <= 46'(sidef.x);
            by_reg    <= 46'(sidef.y);
            errk_reg  <= sq_err_reg[ROOT_BITS-1];
            prefk_reg <= sidef.pref;
        end
    end

    logic signed [ACC_W-1:0] a_base, a_eu, a_ed, a_ku, a_kd;

    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_base (
        .aclk(aclk), .ce(ce), .x_in(bx_reg), .y_in(by_reg), .angle(a_base));
    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_eu (
        .aclk(aclk), .ce(ce), .x_in(ec_reg), .y_in(es_reg), .angle(a_eu));
    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_ed (
        .aclk(aclk), .ce(ce), .x_in(ec_reg), .y_in(ens_reg), .angle(a_ed));
    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_ku (
        .aclk(aclk), .ce(ce), .x_in(k1_reg), .y_in(k2u_reg), .angle(a_ku));
    tlik_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_kd (
        .aclk(aclk), .ce(ce), .x_in(k1_reg), .y_in(k2d_reg), .angle(a_kd));

    // Tags travelling alongside the CORDIC pipelines
    logic cd_vld_reg  [CL];
    logic cd_err_reg  [CL];
    logic cd_pref_reg [CL];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int n = 0; n < CL; n++) cd_vld_reg[n] <= 1'b0;
        end else if (ce) begin
            cd_vld_reg[0] <= vldk_reg;
            for (int n = 1; n < CL; n++) cd_vld_reg[n] <= cd_vld_reg[n-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cd_err_reg[0]  <= errk_reg;
            cd_pref_reg[0] <= prefk_reg;
            for (int n = 1; n < CL; n++) begin
                cd_err_reg[n]  <= cd_err_reg[n-1];
                cd_pref_reg[n] <= cd_pref_reg[n-1];
            end
        end
    end

    // Rounding of the elbow and shoulder angles, half up
    logic signed [35:0] t2u_reg, t2d_reg, t1u_reg, t1d_reg;
    logic               vldr_reg, errr_reg, prefr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vldr_reg <= 1'b0;
        end else if (ce) begin
            vldr_reg <= cd_vld_reg[CL-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            t2u_reg   <= (36'(a_eu) + RND) >>> SH;
            t2d_reg   <= (36'(a_ed) + RND) >>> SH;
            t1u_reg   <= (36'(a_base) - 36'(a_ku) + RND) >>> SH;
            t1d_reg   <= (36'(a_base) - 36'(a_kd) + RND) >>> SH;
            errr_reg  <= cd_err_reg[CL-1];
            prefr_reg <= cd_pref_reg[CL-1];
        end
    end

    // Elbow selection: the preferred elbow first, the other one as fallback
    logic signed [35:0] t1f, t2f, t1s, t2s;
    logic               okf, oks;
    logic [16:0]        sh_next;
    logic [15:0]        el_next;
    logic               eu_next;
    status_t            st_next;

    assign t1f = prefr_reg ? t1u_reg : t1d_reg;
    assign t2f = prefr_reg ? t2u_reg : t2d_reg;
    assign t1s = prefr_reg ? t1d_reg : t1u_reg;
    assign t2s = prefr_reg ? t2d_reg : t2u_reg;
    assign okf = (t1f >= 36'(amin_reg)) && (t1f <= 36'(amax_reg));
    assign oks = (t1s >= 36'(amin_reg)) && (t1s <= 36'(amax_reg));

    always_comb begin
        sh_next = '0;
        el_next = '0;
        eu_next = 1'b0;
        st_next = ST_OK;
        if (errr_reg) begin
            st_next = ST_OUTSIDE;
        end else if (okf) begin
            sh_next = t1f[16:0];
            el_next = t2f[15:0];
            eu_next = prefr_reg;
        end else if (oks) begin
            sh_next = t1s[16:0];
            el_next = t2s[15:0];
            eu_next = !prefr_reg;
        end else begin
            st_next = ST_LIMIT;
        end
    end

    logic        m_tvalid_reg, m_eu_reg;
    logic [16:0] m_sh_reg;
    logic [15:0] m_el_reg;
    status_t     m_st_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ce) begin
            m_tvalid_reg <= vldr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_sh_reg <= sh_next;
            m_el_reg <= el_next;
            m_eu_reg <= eu_next;
            m_st_reg <= st_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b000000, m_eu_reg, m_el_reg, m_sh_reg};
    assign m_tuser  = m_st_reg;

endmodule

>>> rtl/tlik_checker.sv
// Port-level checks for the two-link inverse kinematics block, bound to the
// top level. Depends on tlik_pkg for the status codes.
module tlik_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import tlik_pkg::*;

    // A waiting word must stay offered until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word withdrawn before it was taken");

    // The input side is open whenever the output register can move.
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid || m_tready |-> s_tready)
        else $error("input stalled although the output register is free");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_OK) || (m_tuser == ST_OUTSIDE) || (m_tuser == ST_LIMIT))
        else $error("undefined status code");

    // Failed solutions carry zero angles and elbow flag.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != ST_OK) |-> (m_tdata[33:0] == '0))
        else $error("error word carries a non-zero solution");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

endmodule

bind two_link_inverse_kinematics tlik_checker u_tlik_checker (.*);
